### src/svflp_pkg.sv
// ----------------------------------------------------------------------------
// svflp_pkg
// Shared types, constants and coefficient lookups for the two-pole SVF
// lowpass with output level stage.
// ----------------------------------------------------------------------------
package svflp_pkg;

  localparam int STATE_W  = 40;            // integrator width, wraps
  localparam int PROD_W   = STATE_W + 12;  // products and differences
  localparam int SAMPLE_W = 20;
  localparam int K_W      = 10;            // widest serial coefficient (k <= 512)
  localparam int CNT_W    = $clog2(K_W + 1);
  localparam int PADDR_W  = 4;
  localparam int PDATA_W  = 32;

  localparam logic [12:0] CUTOFF_MAX = 13'h1ffe;
  localparam logic [K_W-1:0] K_MAX   = K_W'(512);
  localparam logic [4:0]  S_BASE     = 5'd24;
  localparam logic [6:0]  M_BASE     = 7'd127;
  localparam logic [4:0]  LVL_SHIFT  = 5'd11;  // 7 for the level, 4 for truncation

  localparam logic signed [STATE_W-1:0] CLAMP_POS = STATE_W'(262144);
  localparam logic signed [STATE_W-1:0] CLAMP_NEG = -STATE_W'(262143);
  localparam logic signed [SAMPLE_W-1:0] Y_MIN = SAMPLE_W'(-524288);
  localparam logic signed [SAMPLE_W-1:0] Y_MAX = SAMPLE_W'(524287);

  typedef struct packed {
    logic [12:0] cutoff_code;
    logic [4:0]  resonance_index;
    logic [7:0]  total_level;
    logic        voff;
  } cfg_t;

  typedef enum logic [1:0] {
    REG_CUTOFF,
    REG_RESON,
    REG_LEVEL,
    REG_VOFF
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_D,
    ST_D_SUB,
    ST_MUL_E,
    ST_BAND_UPD,
    ST_MUL_Q,
    ST_LOW_UPD,
    ST_CLAMP,
    ST_MUL_L,
    ST_FINISH
  } core_state_t;

  function automatic logic [7:0] damp_lut(input logic [4:0] idx);
    logic [7:0] v;
    case (idx)
      5'd0:  v = 8'd192;  5'd1:  v = 8'd176;  5'd2:  v = 8'd160;  5'd3:  v = 8'd144;
      5'd4:  v = 8'd128;  5'd5:  v = 8'd120;  5'd6:  v = 8'd112;  5'd7:  v = 8'd104;
      5'd8:  v = 8'd96;   5'd9:  v = 8'd88;   5'd10: v = 8'd80;   5'd11: v = 8'd72;
      5'd12: v = 8'd64;   5'd13: v = 8'd60;   5'd14: v = 8'd56;   5'd15: v = 8'd52;
      5'd16: v = 8'd48;   5'd17: v = 8'd44;   5'd18: v = 8'd40;   5'd19: v = 8'd36;
      5'd20: v = 8'd32;   5'd21: v = 8'd30;   5'd22: v = 8'd28;   5'd23: v = 8'd26;
      5'd24: v = 8'd24;   5'd25: v = 8'd22;   5'd26: v = 8'd20;   5'd27: v = 8'd18;
      5'd28: v = 8'd16;   5'd29: v = 8'd15;   5'd30: v = 8'd14;   5'd31: v = 8'd13;
      default: v = 8'd192;
    endcase
    return v;
  endfunction

  // gain k: 512 at the top codes, else 256 plus bits [8:1]
  function automatic logic [K_W-1:0] cutoff_k(input logic [12:0] code);
    return (code >= CUTOFF_MAX) ? K_MAX : {2'b01, code[8:1]};
  endfunction

  function automatic logic [4:0] cutoff_s(input logic [12:0] code);
    return S_BASE - {1'b0, code[12:9]};
  endfunction

  function automatic logic [6:0] level_m(input logic [7:0] tl);
    return M_BASE - {1'b0, tl[3:0], 2'b00};
  endfunction

  function automatic logic [4:0] level_shift(input logic [7:0] tl);
    return LVL_SHIFT + {1'b0, tl[7:4]};
  endfunction

  function automatic logic signed [PROD_W-1:0] sext_state(input logic [STATE_W-1:0] v);
    return {{(PROD_W-STATE_W){v[STATE_W-1]}}, v};
  endfunction

  function automatic logic signed [PROD_W-1:0] sext_sample(input logic [SAMPLE_W-1:0] v);
    return {{(PROD_W-SAMPLE_W){v[SAMPLE_W-1]}}, v};
  endfunction

endpackage

### src/svflp_regs.sv
// ----------------------------------------------------------------------------
// svflp_regs
// APB register file: cutoff, resonance, total level and level bypass.
// ----------------------------------------------------------------------------
module svflp_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [svflp_pkg::PADDR_W-1:0] paddr,
  input  logic [svflp_pkg::PDATA_W-1:0] pwdata,
  output logic [svflp_pkg::PDATA_W-1:0] prdata,
  output logic                          pready,
  output svflp_pkg::cfg_t               cfg
);
  import svflp_pkg::*;

  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cutoff_code     <= '0;
      cfg.resonance_index <= '0;
      cfg.total_level     <= '0;
      cfg.voff            <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_CUTOFF: cfg.cutoff_code     <= pwdata[12:0];
        REG_RESON:  cfg.resonance_index <= pwdata[4:0];
        REG_LEVEL:  cfg.total_level     <= pwdata[7:0];
        REG_VOFF:   cfg.voff            <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CUTOFF: prdata = PDATA_W'(cfg.cutoff_code);
      REG_RESON:  prdata = PDATA_W'(cfg.resonance_index);
      REG_LEVEL:  prdata = PDATA_W'(cfg.total_level);
      REG_VOFF:   prdata = PDATA_W'(cfg.voff);
      default:    prdata = '0;
    endcase
  end

endmodule

### src/svflp_mul.sv
// ----------------------------------------------------------------------------
// svflp_mul
// Bit-serial multiplier: signed wide operand times unsigned coefficient,
// one coefficient bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module svflp_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [svflp_pkg::PROD_W-1:0] a,
  input  logic [svflp_pkg::K_W-1:0]           b,
  output logic                                done,
  output logic signed [svflp_pkg::PROD_W-1:0] prod
);
  import svflp_pkg::*;

  logic signed [PROD_W-1:0] ma;
  logic [K_W-1:0]           mb;
  logic signed [PROD_W-1:0] acc;
  logic [CNT_W-1:0]         cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == CNT_W'(1)) && !start;
      if (start) begin
        cnt <= CNT_W'(K_W);
      end else if (cnt != '0) begin
        cnt <= cnt - CNT_W'(1);
      end
    end
  end

  // Horner form: acc = 2*acc + bit*a
  always_ff @(posedge clk) begin
    if (start) begin
      ma  <= a;
      mb  <= b;
      acc <= '0;
    end else if (cnt != '0) begin
      acc <= (acc <<< 1) + (mb[K_W-1] ? ma : '0);
      mb  <= mb << 1;
    end
  end

  assign prod = acc;

endmodule

### src/svflp_core.sv
// ----------------------------------------------------------------------------
// svflp_core
// Filter sequencer: integrator state, step datapath around the shared
// serial multiplier, clamp, level stage and output register.
// ----------------------------------------------------------------------------
module svflp_core (
  input  logic                                  clk,
  input  logic                                  rst,
  input  svflp_pkg::cfg_t                       cfg,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [svflp_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [svflp_pkg::SAMPLE_W-1:0] sample_out
);
  import svflp_pkg::*;

  core_state_t state, state_next;

  logic [STATE_W-1:0]        band, low;
  logic signed [PROD_W-1:0]  tmp, tmp2;
  logic signed [SAMPLE_W-1:0] yreg;

  logic                      mul_start, mul_done;
  logic signed [PROD_W-1:0]  mul_a, mul_p;
  logic [K_W-1:0]            mul_b;

  logic [K_W-1:0]            k_val;
  logic [4:0]                s_val;
  logic [4:0]                lsh;
  logic [PROD_W-1:0]         ceil_mask;
  logic signed [PROD_W-1:0]  x_ext, low_inc, lvl_shr;
  logic [STATE_W-1:0]        band_next;
  logic signed [STATE_W-1:0] low_s, neg2;
  logic signed [SAMPLE_W-1:0] y_clamp;
  logic                      accept, out_free;

  assign k_val     = cutoff_k(cfg.cutoff_code);
  assign s_val     = cutoff_s(cfg.cutoff_code);
  assign lsh       = level_shift(cfg.total_level);
  assign ceil_mask = ~({PROD_W{1'b1}} << s_val);

  assign accept   = in_valid & in_ready;
  assign out_free = !out_valid || out_ready;

  // x = sample >> 1, floor
  assign x_ext     = sext_sample(sample_in) >>> 1;
  assign band_next = band + tmp2[STATE_W-1:0];
  assign low_inc   = tmp2 >>> s_val;

  assign low_s = low;
  assign neg2  = -(low_s <<< 1);
  always_comb begin
    if (low_s > CLAMP_POS)      y_clamp = Y_MIN;
    else if (low_s < CLAMP_NEG) y_clamp = Y_MAX;
    else                        y_clamp = neg2[SAMPLE_W-1:0];
  end

  // level shift already folds in the drop to 1/16, so this is (lv >> 4)
  assign lvl_shr = mul_p >>> lsh;

  svflp_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .prod  (mul_p)
  );

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    mul_start  = 1'b0;
    mul_a      = sext_state(band);
    mul_b      = k_val;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        mul_b    = K_W'(damp_lut(cfg.resonance_index));
        if (in_valid) begin
          mul_start  = 1'b1;
          state_next = ST_MUL_D;
        end
      end
      ST_MUL_D:    if (mul_done) state_next = ST_D_SUB;
      ST_D_SUB: begin
        // e = x - low - 2*ceil(damp*band/256)
        mul_a      = tmp - ((tmp2 >>> 8) <<< 1);
        mul_start  = 1'b1;
        state_next = ST_MUL_E;
      end
      ST_MUL_E:    if (mul_done) state_next = ST_BAND_UPD;
      ST_BAND_UPD: begin
        mul_a      = sext_state(band_next);
        mul_start  = 1'b1;
        state_next = ST_MUL_Q;
      end
      ST_MUL_Q:    if (mul_done) state_next = ST_LOW_UPD;
      ST_LOW_UPD:  state_next = ST_CLAMP;
      ST_CLAMP: begin
        mul_a = sext_sample(y_clamp);
        mul_b = K_W'(level_m(cfg.total_level));
        if (cfg.voff) begin
          state_next = ST_FINISH;
        end else begin
          mul_start  = 1'b1;
          state_next = ST_MUL_L;
        end
      end
      ST_MUL_L:    if (mul_done) state_next = ST_FINISH;
      ST_FINISH:   if (out_free) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      band <= '0;
      low  <= '0;
    end else begin
      if (state == ST_BAND_UPD) band <= band_next;
      if (state == ST_LOW_UPD)  low  <= low + low_inc[STATE_W-1:0];
    end
  end

  // step temporaries
  always_ff @(posedge clk) begin
    if (accept) tmp <= x_ext - sext_state(low);
    if (mul_done) begin
      case (state)
        ST_MUL_D: tmp2 <= mul_p + PROD_W'(255);       // ceil by 256
        ST_MUL_E: tmp2 <= mul_p >>> s_val;
        ST_MUL_Q: tmp2 <= mul_p + ceil_mask;          // ceil by 2^s
        default:  ;
      endcase
    end
    if (state == ST_CLAMP) yreg <= y_clamp;
    if (state == ST_MUL_L && mul_done) yreg <= {lvl_shr[SAMPLE_W-5:0], 4'b0000};
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) sample_out <= yreg;
  end

endmodule

### src/svf_lowpass_with_level_top.sv
// ----------------------------------------------------------------------------
// svf_lowpass_with_level_top
// Two-pole state-variable lowpass with optional output level stage.
// Input channel (in_valid/in_ready, sample_in) takes one sample per item;
// output channel (out_valid/out_ready, sample_out) returns one item each.
// Settings go through the APB port: cutoff 0x0, resonance 0x4, total level
// 0x8, voff 0xC; write them only while no item is in flight.
// One item at a time; the next item can be taken in the same cycle that
// out_valid rises. Item spacing is set by the shared bit-serial multiplier:
// 3 products per item with voff=1, 4 with voff=0.
// A stalled receiver leaves the result in the output register; the next item
// is still taken and computed, and waits at the end until that register frees.
// Reset (rst, synchronous) zeroes both integrators, empties the output and
// loads default settings (voff=1, all others zero).
// ----------------------------------------------------------------------------
module svf_lowpass_with_level_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [svflp_pkg::PADDR_W-1:0]         paddr,
  input  logic [svflp_pkg::PDATA_W-1:0]         pwdata,
  output logic [svflp_pkg::PDATA_W-1:0]         prdata,
  output logic                                  pready,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [svflp_pkg::SAMPLE_W-1:0] sample_in,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [svflp_pkg::SAMPLE_W-1:0] sample_out
);
  import svflp_pkg::*;

  cfg_t cfg;

  // register file
  svflp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer, integrators, multiplier and output register
  svflp_core u_core (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .sample_in  (sample_in),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sample_out (sample_out)
  );

`ifndef SYNTHESIS
  // a taken item keeps the core busy
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("in_ready stayed high after an item was taken");

  // a result is only loaded as the core returns to idle
  a_result_at_idle: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> in_ready)
    else $error("result loaded while core still busy");

  // reset leaves the block empty and ready
  a_reset_state: assert property (@(posedge clk)
    $past(rst) |-> in_ready && !out_valid && cfg.voff)
    else $error("block not empty and ready after reset");
`endif

endmodule
